// ===== src/ir_pulse_distance_frame_encoder_defines.svh =====
// Assertion macros used by the symbol generator of the pulse-distance frame encoder.
`ifndef IR_PULSE_DISTANCE_FRAME_ENCODER_DEFINES_SVH
`define IR_PULSE_DISTANCE_FRAME_ENCODER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IRPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define IRPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/irpd_pkg.sv =====
// Types, constants and helper functions of the pulse-distance frame encoder.
package irpd_pkg;

	localparam int RATE_W    = 27;
	localparam int CFG_IDX_W = 1;
	localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000000);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TICK_RATE = 1'b0,
		CFG_INVERT    = 1'b1
	} cfg_idx_t;

	localparam int US_W      = 12;
	localparam int US_PER_S  = 1000000;
	localparam int DUR_BITS  = 15;
	localparam int TICKS_W   = 15;
	localparam int DUR_MAX   = (1 << DUR_BITS) - 1;
	localparam int REM_W     = US_W + RATE_W;

	// One million is 2^6 times 15625. An unsaturated product shifted right by
	// six stays below 2^(DUR_BITS+14), since 15625 is below 2^14, and is then
	// divided by 15625 through a rounded-up reciprocal with 14 guard bits.
	localparam int US_SHIFT = 6;
	localparam int US_ODD   = US_PER_S >> US_SHIFT;
	localparam int Y_W      = DUR_BITS + 14;
	localparam int M_W      = Y_W + 1;
	localparam int RECIP_SH = Y_W + 14;
	localparam int RP_W     = Y_W + M_W;
	localparam logic [M_W-1:0] RECIP =
		M_W'(((64'd1 << RECIP_SH) + 64'(US_ODD - 1)) / 64'(US_ODD));
	localparam logic [REM_W-1:0] SAT_PROD = REM_W'(64'(DUR_MAX + 1) * 64'(US_PER_S));

	localparam int LEADER_MARK_US  = 3380;
	localparam int LEADER_SPACE_US = 1690;
	localparam int BIT_MARK_US     = 420;
	localparam int ONE_SPACE_US    = 1270;
	localparam int END_SPACE_RAW   = 32'h7FFF;

	typedef enum logic [1:0] {
		DUR_LEADER_MARK  = 2'd0,
		DUR_LEADER_SPACE = 2'd1,
		DUR_BIT_MARK     = 2'd2,
		DUR_ONE_SPACE    = 2'd3
	} dur_sel_t;

	localparam int NUM_DUR = 4;

	typedef enum logic [1:0] {
		SCL_IDLE,
		SCL_LOAD,
		SCL_DIV
	} scl_state_t;

	function automatic logic [US_W-1:0] dur_us(dur_sel_t sel);
		logic [US_W-1:0] us;
		unique case (sel)
			DUR_LEADER_MARK:  us = US_W'(LEADER_MARK_US);
			DUR_LEADER_SPACE: us = US_W'(LEADER_SPACE_US);
			DUR_BIT_MARK:     us = US_W'(BIT_MARK_US);
			DUR_ONE_SPACE:    us = US_W'(ONE_SPACE_US);
			default:          us = '0;
		endcase
		return us;
	endfunction

	// Saturate a constant tick count and fit it to the output field.
	function automatic logic [TICKS_W-1:0] sat_const(int v);
		int s;
		s = (v > DUR_MAX) ? DUR_MAX : v;
		return TICKS_W'(s);
	endfunction

	localparam logic [TICKS_W-1:0] END_TICKS = sat_const(END_SPACE_RAW);
	localparam logic [TICKS_W-1:0] MAX_TICKS = TICKS_W'(DUR_MAX);

	typedef struct packed {
		logic [15:0] vendor_word;
		logic [7:0]  sys_code;
		logic [7:0]  device_address;
		logic [7:0]  command_byte;
		logic [7:0]  check_byte;
	} scan_code_t;

	localparam int FRAME_W = $bits(scan_code_t);

	typedef struct packed {
		logic               first_level;
		logic [TICKS_W-1:0] first_ticks;
		logic               second_level;
		logic [TICKS_W-1:0] second_ticks;
		logic               frame_end;
	} symbol_t;

	typedef struct packed {
		logic               busy;
		logic               invert;
		logic [TICKS_W-1:0] leader_mark;
		logic [TICKS_W-1:0] leader_space;
		logic [TICKS_W-1:0] bit_mark;
		logic [TICKS_W-1:0] one_space;
	} timing_t;

	localparam int SYMBOLS = 50;
	localparam int IDX_W   = 6;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SYMBOLS - 1);

endpackage

// ===== src/irpd_scaler.sv =====
// Configuration registers and the shared multiply and divide unit for tick durations.
module irpd_scaler (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  irpd_pkg::cfg_idx_t            wr_index,
	input  logic [irpd_pkg::RATE_W-1:0]   wr_data,
	output irpd_pkg::timing_t             timing
);

	logic [irpd_pkg::RATE_W-1:0]  rate_q;
	logic                         invert_q;
	irpd_pkg::scl_state_t         state_q, state_d;
	irpd_pkg::dur_sel_t           sel_q, sel_d;
	logic [irpd_pkg::REM_W-1:0]   prod_q, prod_d;
	logic [irpd_pkg::TICKS_W-1:0] dur_q [irpd_pkg::NUM_DUR];
	logic [irpd_pkg::TICKS_W-1:0] result;
	logic [irpd_pkg::Y_W-1:0]     scaled;
	logic [irpd_pkg::RP_W-1:0]    recip_prod;
	logic                         saturate;
	logic                         done;
	logic                         rate_wr;

	assign rate_wr = wr_en && (wr_index == irpd_pkg::CFG_TICK_RATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q   <= irpd_pkg::RATE_RESET;
			invert_q <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				irpd_pkg::CFG_TICK_RATE: rate_q   <= wr_data;
				irpd_pkg::CFG_INVERT:    invert_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	// Division by one million: a product at or above the saturation bound is
	// clipped, anything below is shifted by six and multiplied by the
	// reciprocal of 15625.
	assign saturate   = prod_q >= irpd_pkg::SAT_PROD;
	assign scaled     = prod_q[irpd_pkg::US_SHIFT +: irpd_pkg::Y_W];
	assign recip_prod = irpd_pkg::RP_W'(scaled) * irpd_pkg::RP_W'(irpd_pkg::RECIP);
	assign done       = state_q == irpd_pkg::SCL_DIV;
	assign result = saturate ? irpd_pkg::MAX_TICKS :
		irpd_pkg::TICKS_W'(recip_prod[irpd_pkg::RECIP_SH +: irpd_pkg::DUR_BITS]);

	always_comb begin
		state_d = state_q;
		sel_d   = sel_q;
		prod_d  = prod_q;
		unique case (state_q)
			irpd_pkg::SCL_IDLE: begin
			end
			irpd_pkg::SCL_LOAD: begin
				prod_d  = irpd_pkg::REM_W'(irpd_pkg::dur_us(sel_q)) *
					irpd_pkg::REM_W'(rate_q);
				state_d = irpd_pkg::SCL_DIV;
			end
			irpd_pkg::SCL_DIV: begin
				if (sel_q == irpd_pkg::DUR_ONE_SPACE) begin
					state_d = irpd_pkg::SCL_IDLE;
				end else begin
					sel_d   = irpd_pkg::dur_sel_t'(sel_q + 2'd1);
					state_d = irpd_pkg::SCL_LOAD;
				end
			end
			default: state_d = irpd_pkg::SCL_IDLE;
		endcase
		// A new tick rate restarts the whole pass.
		if (rate_wr) begin
			sel_d   = irpd_pkg::DUR_LEADER_MARK;
			state_d = irpd_pkg::SCL_LOAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= irpd_pkg::SCL_IDLE;
			sel_q   <= irpd_pkg::DUR_LEADER_MARK;
			for (int i = 0; i < irpd_pkg::NUM_DUR; i++) begin
				dur_q[i] <= irpd_pkg::sat_const(
					int'(irpd_pkg::dur_us(irpd_pkg::dur_sel_t'(2'(i)))));
			end
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
			if (done) begin
				dur_q[sel_q] <= result;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
	end

	assign timing.busy         = state_q != irpd_pkg::SCL_IDLE;
	assign timing.invert       = invert_q;
	assign timing.leader_mark  = dur_q[irpd_pkg::DUR_LEADER_MARK];
	assign timing.leader_space = dur_q[irpd_pkg::DUR_LEADER_SPACE];
	assign timing.bit_mark     = dur_q[irpd_pkg::DUR_BIT_MARK];
	assign timing.one_space    = dur_q[irpd_pkg::DUR_ONE_SPACE];

endmodule

// ===== src/irpd_front.sv =====
// Input side: accepts scan codes into a short queue that feeds the symbol generator.
module irpd_front #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  irpd_pkg::scan_code_t code,
	input  logic                 hold,
	output logic                 full,
	output logic                 q_valid,
	output irpd_pkg::scan_code_t q_frame,
	input  logic                 q_take
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	irpd_pkg::scan_code_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]     count_q;
	logic                 wr, rd;

	// Intake pauses while the durations are being rebuilt.
	assign full    = (count_q == CNT_FULL) || hold;
	assign q_valid = count_q != '0;
	assign q_frame = mem_q[rd_ptr_q];
	assign wr      = push && !full;
	assign rd      = q_take && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= code;
		end
	end

endmodule

// ===== src/irpd_back.sv =====
// Symbol generator: walks one frame through its fifty symbols into an output register.
`include "ir_pulse_distance_frame_encoder_defines.svh"

module irpd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  irpd_pkg::scan_code_t q_frame,
	output logic                 q_take,
	input  irpd_pkg::timing_t    timing,
	output logic                 empty,
	input  logic                 pop,
	output irpd_pkg::symbol_t    symbol
);

	logic                         active_q, active_d;
	logic [irpd_pkg::IDX_W-1:0]   idx_q, idx_d;
	logic [irpd_pkg::FRAME_W-1:0] frame_q, frame_d;
	logic                         out_valid_q, out_valid_d;
	irpd_pkg::symbol_t            out_q, out_d;
	irpd_pkg::symbol_t            sym;
	logic                         advance;
	logic                         can_load;

	always_comb begin
		sym.first_level  = !timing.invert;
		sym.second_level = timing.invert;
		sym.first_ticks  = timing.bit_mark;
		sym.second_ticks = frame_q[irpd_pkg::FRAME_W-1] ? timing.one_space : timing.bit_mark;
		sym.frame_end    = 1'b0;
		priority if (idx_q == '0) begin
			sym.first_ticks  = timing.leader_mark;
			sym.second_ticks = timing.leader_space;
		end else if (idx_q == irpd_pkg::LAST_IDX) begin
			sym.second_ticks = irpd_pkg::END_TICKS;
			sym.frame_end    = 1'b1;
		end
	end

	assign advance  = !out_valid_q || pop;
	assign can_load = q_valid && !timing.busy;

	always_comb begin
		q_take      = 1'b0;
		active_d    = active_q;
		idx_d       = idx_q;
		frame_d     = frame_q;
		out_valid_d = out_valid_q;
		out_d       = out_q;
		if (advance) begin
			out_valid_d = active_q;
			out_d       = sym;
		end
		if (active_q && advance) begin
			if (idx_q == irpd_pkg::LAST_IDX) begin
				if (can_load) begin
					q_take  = 1'b1;
					frame_d = q_frame;
					idx_d   = '0;
				end else begin
					active_d = 1'b0;
				end
			end else begin
				idx_d = idx_q + 1'b1;
				if (idx_q != '0) begin
					frame_d = {frame_q[irpd_pkg::FRAME_W-2:0], 1'b0};
				end
			end
		end else if (!active_q && can_load) begin
			q_take   = 1'b1;
			frame_d  = q_frame;
			idx_d    = '0;
			active_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			active_q    <= active_d;
			idx_q       <= idx_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		frame_q <= frame_d;
		out_q   <= out_d;
	end

	assign empty  = !out_valid_q;
	assign symbol = out_q;

	`IRPD_ASSERT_IMP(a_take_needs_timing, clk, arst_n, q_take, !timing.busy, "frame started during duration rebuild")
	`IRPD_ASSERT_NXT(a_take_starts_leader, clk, arst_n, q_take, active_q && (idx_q == '0), "taken frame did not start at its leader")
	`IRPD_ASSERT_IMP(a_levels_opposite, clk, arst_n, out_valid_q, out_q.first_level != out_q.second_level, "symbol halves share one level")

endmodule

// ===== src/ir_pulse_distance_frame_encoder.sv =====
// Top level of the 48-bit pulse-distance infrared frame encoder.
//
// Scan codes enter through a queue-style port: a code is transferred on a
// rising edge with push high and full low. Each code yields fifty symbols
// (leader, 48 data bits most significant first, ending mark), and each symbol
// is a transfer on the result side, taken on an edge with pop high and empty low.
// When the generator is idle, a code's first symbol reaches the result port via
// the queue, the generator's frame register and the output register. The
// generator makes one symbol per cycle while the receiver keeps taking them and
// no rebuild holds back the next code, so it paces the stream. Further codes
// wait in a queue of QUEUE_DEPTH entries; full rises when every entry is occupied.
// When the receiver stalls, the current symbol holds in the output register and
// the generator waits; the input side keeps taking codes until the queue fills.
// Writing the tick rate rebuilds four durations in a shared multiplier and a
// reciprocal divide by one million, each passing a load and a divide state, with
// full held high meanwhile. Reset loads the durations for the 1 MHz reset rate,
// so no rebuild follows reset; the queue and output register come up empty.
module ir_pulse_distance_frame_encoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  irpd_pkg::scan_code_t           code,
	output logic                           empty,
	input  logic                           pop,
	output irpd_pkg::symbol_t              symbol,
	input  logic                           wr_en,
	input  irpd_pkg::cfg_idx_t             wr_index,
	input  logic [irpd_pkg::RATE_W-1:0]    wr_data
);

	irpd_pkg::timing_t    timing;
	logic                 q_valid;
	logic                 q_take;
	irpd_pkg::scan_code_t q_frame;

	// Configuration registers and the duration table.
	irpd_scaler u_scaler (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.timing   (timing)
	);

	// Intake and the queue between the two halves.
	irpd_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.code    (code),
		.hold    (timing.busy),
		.full    (full),
		.q_valid (q_valid),
		.q_frame (q_frame),
		.q_take  (q_take)
	);

	// Symbol sequencing and the output register.
	irpd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_frame (q_frame),
		.q_take  (q_take),
		.timing  (timing),
		.empty   (empty),
		.pop     (pop),
		.symbol  (symbol)
	);

endmodule
